>>> sv/cholesky_decomposition_unit_assert.svh
// Assertion macros shared by the block.
`ifndef CHOLESKY_DECOMPOSITION_UNIT_ASSERT_SVH
`define CHOLESKY_DECOMPOSITION_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CDU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/cdu_pkg.sv
package cdu_pkg;

  localparam int DEFAULT_MAX_N = 8;
  localparam int DataW = 32;
  localparam int DetW = 64;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_MATRIX_SIZE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_PIVOT = 1'd1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FIRST_PIVOT = 2'd1;
  localparam logic [1:0] ST_LATER_PIVOT = 2'd2;

  localparam logic [3:0] SIZE_RESET = 4'd3;
  localparam logic [15:0] PIVOT_RESET = 16'd1;

  localparam logic [32:0] DP_CAP = 33'h1_0000_0000;
  localparam logic [32:0] DP_SQ_LIMIT = 33'd3037000500;
  localparam logic signed [63:0] DET_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

>>> sv/cdu_if.sv
interface cdu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] matrix_element;
  logic               last_element;
  modport source (output valid, output matrix_element, output last_element, input ready);
  modport sink (input valid, input matrix_element, input last_element, output ready);
endinterface

interface cdu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] factor_value;
  logic [1:0]         status;
  logic signed [63:0] determinant;
  logic               is_last;
  modport source (output valid, output factor_value, output status, output determinant,
                  output is_last, input ready);
  modport sink (input valid, input factor_value, input status, input determinant,
                input is_last, output ready);
endinterface

>>> sv/cholesky_decomposition_unit.sv
// Cholesky factorization of a symmetric matrix of order n (1 to MAX_N) in signed Q16.16.
// Elements are loaded one per cycle in row-major order into a single-port-read matrix
// memory; the item flagged last starts the in-place factorization. Each multiply-subtract
// reads its operands through the one memory read port, then multiplies, then subtracts;
// square roots and divisions are computed bit-serially. Each output item is read from
// memory and held until taken (n*n items, upper triangle zero, determinant on the last). A
// pivot below the threshold yields a single failure item. No input item is taken during
// factorization or output.
module cholesky_decomposition_unit #(
  parameter int MAX_N = cdu_pkg::DEFAULT_MAX_N
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cdu_in_if.sink                       in_ch,
  cdu_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [cdu_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cdu_pkg::CfgDataW-1:0] cfg_data
);
  import cdu_pkg::*;
  `include "cholesky_decomposition_unit_assert.svh"

  localparam int Depth = MAX_N * MAX_N;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NW = $clog2(MAX_N + 1);
  localparam int CW = $clog2(Depth + 1);

  typedef enum logic [4:0] {
    S_LOAD, S_DIAG_RD, S_DIAG_GET, S_DK_RD, S_DK_MUL, S_DK_SUB, S_CHECK, S_SQRT,
    S_SQRT_WR, S_DP, S_OFF_RD, S_OFF_GET, S_OA_RD, S_OB_RD, S_O_MUL, S_O_SUB,
    S_DIV, S_DIV_WR, S_DET, S_OUT_RD, S_OUT_GET, S_OUT_SHOW
  } state_t;

  state_t state_r;
  logic [3:0] size_r;
  logic [15:0] pivot_min_r;
  logic [CW-1:0] count_r;
  logic [NW-1:0] j_r, i_r, k_r, oi_r, oj_r;
  logic signed [31:0] acc_r, opa_r, piv_r;
  logic signed [63:0] prod_r;
  logic [47:0] sq_v_r, sq_r_r, dq_r;
  logic [4:0] sq_cnt_r;
  logic [32:0] rem_r;
  logic [5:0] dv_cnt_r;
  logic div_neg_r;
  logic [32:0] dp_r;
  logic signed [63:0] det_r;
  logic [31:0] mem [Depth];
  logic [31:0] rdata_r;

  logic out_valid_r, out_last_r;
  logic signed [31:0] out_fv_r;
  logic [1:0] out_st_r;
  logic signed [63:0] out_det_r;

  logic [NW-1:0] n_eff;
  logic [16:0] thr;
  logic [NW-1:0] rd_row, rd_col;
  logic rd_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [31:0] wr_data;
  logic signed [31:0] sub_val;
  logic [47:0] sq_bit, sq_trial;
  logic [32:0] dv_trial;
  logic signed [31:0] quot;
  logic [57:0] dp_prod;
  logic [41:0] dp_shift;

  logic in_done, out_done, out_fail, fail_zero;

  function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] row, input logic [NW-1:0] col,
                                            input logic [NW-1:0] n);
    logic [2*NW:0] t;
    t = (2*NW+1)'(row) * (2*NW+1)'(n) + (2*NW+1)'(col);
    return t[AW-1:0];
  endfunction

  always_comb begin
    if (size_r == 4'd0) begin
      n_eff = NW'(1);
    end else if (32'(size_r) > MAX_N) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(size_r);
    end
    thr = (pivot_min_r == 16'd0) ? 17'd1 : {1'b0, pivot_min_r};
  end

  always_comb begin
    rd_en = 1'b1;
    rd_row = j_r;
    rd_col = k_r;
    unique case (state_r)
      S_DIAG_RD: rd_col = j_r;
      S_DK_RD, S_OB_RD: rd_col = k_r;
      S_OFF_RD: begin
        rd_row = i_r;
        rd_col = j_r;
      end
      S_OA_RD: rd_row = i_r;
      S_OUT_RD: begin
        rd_row = oi_r;
        rd_col = oj_r;
      end
      default: rd_en = 1'b0;
    endcase
    rd_addr = addr_of(rd_row, rd_col, n_eff);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = addr_of(j_r, j_r, n_eff);
    wr_data = sq_r_r[31:0];
    unique case (state_r)
      S_LOAD: begin
        wr_en = in_ch.valid && (count_r < CW'(Depth));
        wr_addr = count_r[AW-1:0];
        wr_data = in_ch.matrix_element;
      end
      S_SQRT_WR: wr_en = 1'b1;
      S_DIV_WR: begin
        wr_en = 1'b1;
        wr_addr = addr_of(i_r, j_r, n_eff);
        wr_data = quot;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    sub_val = sat32(64'(acc_r) - 64'(sat32(prod_r >>> 16)));
    sq_bit = 48'd1 << (6'd46 - {sq_cnt_r, 1'b0});
    sq_trial = sq_r_r + sq_bit;
    dv_trial = {rem_r[31:0], dq_r[47]};
    if (div_neg_r) begin
      quot = (dq_r > 48'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed({1'b0, dq_r}));
    end else begin
      quot = (dq_r > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dq_r[31:0];
    end
    dp_prod = 58'(dp_r) * 58'($unsigned(piv_r[24:0]));
    dp_shift = dp_prod[57:16];
  end

  assign in_ch.ready = (state_r == S_LOAD);
  assign out_ch.valid = out_valid_r;
  assign out_ch.factor_value = out_fv_r;
  assign out_ch.status = out_st_r;
  assign out_ch.determinant = out_det_r;
  assign out_ch.is_last = out_last_r;

  assign in_done = in_ch.valid && in_ch.ready && in_ch.last_element;
  assign out_done = out_ch.valid && out_ch.ready && out_ch.is_last;
  assign out_fail = out_ch.valid && (out_ch.status != ST_OK);
  assign fail_zero = out_ch.is_last && (out_ch.factor_value == 32'sd0) &&
                     (out_ch.determinant == 64'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      size_r <= SIZE_RESET;
      pivot_min_r <= PIVOT_RESET;
      count_r <= '0;
      dp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MATRIX_SIZE: size_r <= cfg_data[3:0];
          CFG_MIN_PIVOT: pivot_min_r <= cfg_data;
          default: size_r <= size_r;
        endcase
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_ch.valid) begin
            if (in_ch.last_element) begin
              count_r <= '0;
              j_r <= '0;
              state_r <= S_DIAG_RD;
            end else if (count_r < CW'(Depth)) begin
              count_r <= count_r + CW'(1);
            end
          end
        end
        S_DIAG_RD: state_r <= S_DIAG_GET;
        S_DIAG_GET: begin
          acc_r <= rdata_r;
          k_r <= '0;
          state_r <= (j_r == '0) ? S_CHECK : S_DK_RD;
        end
        S_DK_RD: state_r <= S_DK_MUL;
        S_DK_MUL: begin
          prod_r <= 64'($signed(rdata_r)) * 64'($signed(rdata_r));
          state_r <= S_DK_SUB;
        end
        S_DK_SUB: begin
          acc_r <= sub_val;
          k_r <= k_r + NW'(1);
          state_r <= (k_r + NW'(1) == j_r) ? S_CHECK : S_DK_RD;
        end
        S_CHECK: begin
          if (34'(acc_r) < $signed({17'd0, thr})) begin
            out_valid_r <= 1'b1;
            out_fv_r <= '0;
            out_det_r <= '0;
            out_last_r <= 1'b1;
            out_st_r <= (j_r == '0) ? ST_FIRST_PIVOT : ST_LATER_PIVOT;
            state_r <= S_OUT_SHOW;
          end else begin
            sq_v_r <= {acc_r[31:0], 16'd0};
            sq_r_r <= '0;
            sq_cnt_r <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_v_r >= sq_trial) begin
            sq_v_r <= sq_v_r - sq_trial;
            sq_r_r <= (sq_r_r >> 1) + sq_bit;
          end else begin
            sq_r_r <= sq_r_r >> 1;
          end
          sq_cnt_r <= sq_cnt_r + 5'd1;
          if (sq_cnt_r == 5'd23) begin
            state_r <= S_SQRT_WR;
          end
        end
        S_SQRT_WR: begin
          piv_r <= sq_r_r[31:0];
          state_r <= S_DP;
        end
        S_DP: begin
          if (j_r == '0) begin
            dp_r <= {1'b0, piv_r};
          end else begin
            dp_r <= (dp_shift > 42'(DP_CAP)) ? DP_CAP : dp_shift[32:0];
          end
          i_r <= j_r + NW'(1);
          if (j_r + NW'(1) < n_eff) begin
            state_r <= S_OFF_RD;
          end else begin
            state_r <= S_DET;
          end
        end
        S_OFF_RD: state_r <= S_OFF_GET;
        S_OFF_GET: begin
          acc_r <= rdata_r;
          k_r <= '0;
          state_r <= (j_r == '0) ? S_DIV : S_OA_RD;
          if (j_r == '0) begin
            div_neg_r <= rdata_r[31];
            dq_r <= {(rdata_r[31] ? 32'(-rdata_r) : rdata_r), 16'd0};
            rem_r <= '0;
            dv_cnt_r <= '0;
          end
        end
        S_OA_RD: state_r <= S_OB_RD;
        S_OB_RD: begin
          opa_r <= rdata_r;
          state_r <= S_O_MUL;
        end
        S_O_MUL: begin
          prod_r <= 64'(opa_r) * 64'($signed(rdata_r));
          state_r <= S_O_SUB;
        end
        S_O_SUB: begin
          acc_r <= sub_val;
          k_r <= k_r + NW'(1);
          if (k_r + NW'(1) == j_r) begin
            div_neg_r <= sub_val[31];
            dq_r <= {(sub_val[31] ? 32'(-sub_val) : 32'(sub_val)), 16'd0};
            rem_r <= '0;
            dv_cnt_r <= '0;
            state_r <= S_DIV;
          end else begin
            state_r <= S_OA_RD;
          end
        end
        S_DIV: begin
          if (dv_trial >= {1'b0, piv_r}) begin
            rem_r <= dv_trial - {1'b0, piv_r};
            dq_r <= {dq_r[46:0], 1'b1};
          end else begin
            rem_r <= dv_trial;
            dq_r <= {dq_r[46:0], 1'b0};
          end
          dv_cnt_r <= dv_cnt_r + 6'd1;
          if (dv_cnt_r == 6'd47) begin
            state_r <= S_DIV_WR;
          end
        end
        S_DIV_WR: begin
          i_r <= i_r + NW'(1);
          if (i_r + NW'(1) < n_eff) begin
            state_r <= S_OFF_RD;
          end else begin
            j_r <= j_r + NW'(1);
            state_r <= S_DIAG_RD;
          end
        end
        S_DET: begin
          det_r <= (dp_r >= DP_SQ_LIMIT) ? DET_MAX
                                         : $signed(64'(dp_r[31:0]) * 64'(dp_r[31:0]));
          oi_r <= '0;
          oj_r <= '0;
          state_r <= S_OUT_RD;
        end
        S_OUT_RD: state_r <= S_OUT_GET;
        S_OUT_GET: begin
          out_valid_r <= 1'b1;
          out_fv_r <= (oj_r > oi_r) ? 32'sd0 : rdata_r;
          out_st_r <= ST_OK;
          out_last_r <= (oi_r == n_eff - NW'(1)) && (oj_r == n_eff - NW'(1));
          out_det_r <= ((oi_r == n_eff - NW'(1)) && (oj_r == n_eff - NW'(1))) ? det_r : '0;
          state_r <= S_OUT_SHOW;
        end
        S_OUT_SHOW: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_LOAD;
            end else begin
              if (oj_r == n_eff - NW'(1)) begin
                oj_r <= '0;
                oi_r <= oi_r + NW'(1);
              end else begin
                oj_r <= oj_r + NW'(1);
              end
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  `CDU_ASSERT_ALWAYS(a_no_overlap, !(in_ch.ready && out_ch.valid), "Input open during output.")
  `CDU_ASSERT_NEXT(a_last_returns, out_done, in_ch.ready, "No return to loading.")
  `CDU_ASSERT_ALWAYS(a_fail_shape, !out_fail || fail_zero, "Failure item is malformed.")
  `CDU_ASSERT_NEXT(a_start_factor, in_done, !in_ch.ready && !out_ch.valid, "Work did not start.")

endmodule
